[hw/rtl/kcst_pkg.sv]
// ----------------------------------------------------------------------------
// kcst_pkg
// shared types and constants of the keyed capture statistics table
// ----------------------------------------------------------------------------
package kcst_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int N_KINDS     = 3;
  localparam int N_WORDS     = 12;

  localparam logic [2:0] BIND_ROOT   = 3'h1;
  localparam logic [2:0] BIND_PUSHED = 3'h2;
  localparam logic [2:0] BIND_TABLE  = 3'h4;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_ACCUM    = 3'd1,
    MODE_PRESENT  = 3'd2,
    MODE_OVERFLOW = 3'd3,
    MODE_STOP     = 3'd4,
    MODE_CLEAR    = 3'd5,
    MODE_READ     = 3'd6,
    MODE_UNUSED   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_CAPTURING = 2'd1,
    PH_CAPTURED  = 2'd2,
    PH_INVALID   = 2'd3
  } phase_t;

  // one table row
  typedef struct packed {
    logic [63:0]              key;
    logic [31:0]              tag;
    logic [2:0]               seen;
    logic [2:0]               changed;
    logic [63:0]              first_fr;
    logic [63:0]              last_fr;
    logic [63:0]              cmd_total;
    logic [63:0]              sub_count;
    logic [N_KINDS-1:0][63:0] fp_first;
    logic [N_KINDS-1:0][63:0] fp_last;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // accumulate request fields that the row update needs
  typedef struct packed {
    logic [63:0]              key;
    logic [63:0]              frame;
    logic [31:0]              tag;
    logic [31:0]              cmd;
    logic [2:0]               seen;
    logic [N_KINDS-1:0][63:0] fp;
  } acc_t;

endpackage

[hw/rtl/keyed_capture_stats_table_top.sv]
// ----------------------------------------------------------------------------
// keyed_capture_stats_table_top
// capture session controller with a keyed record table in one ram
// ----------------------------------------------------------------------------
// usage
//   requests enter on the in_ stream, mode in in_tuser. each request gives one
//   summary result on the out_ stream, or twelve record words for a read of a
//   stored record; out_tlast marks the final result of a request.
//   one request is worked on at a time. a non-accumulate request goes to the
//   response step, which registers its result, and the block then takes the
//   next request. an accumulate request in a capture scans the stored keys
//   one per cycle through the ram read port, then writes the row back, or sets
//   the overflow flag for a new key when the table is full. a record read goes
//   to the read step, which registers its words in order, one word a cycle
//   while the receiver takes them.
//   the output register lets a new request be accepted while the last
//   result still waits; a stalled receiver holds the block in its emit step.
//   reset clears the session summary and record count; ram rows are written
//   in full when created, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_capture_stats_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // session, frame, record key, pipeline tag, command count, filter setting,
  // bindings seen, root fingerprint, pushed fingerprint, table fingerprint,
  // read index
  input  logic [471:0] in_tdata,
  // mode
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // capture state, session, start frame, end frame, present count,
  // record count, overflow flag, filter, record word
  output logic [343:0] out_tdata,
  // word_number, record_valid
  output logic [4:0]   out_tuser,
  output logic         out_tlast
);

  localparam int IDX_W = kcst_pkg::IDX_W;
  localparam int CNT_W = kcst_pkg::CNT_W;
  localparam int CMP_W = CNT_W + 6;

  typedef enum logic [2:0] {
    ST_IN, ST_SEARCH, ST_UPD, ST_RESP, ST_RD
  } state_t;

  state_t state_r;

  kcst_pkg::phase_t phase_r;
  logic [63:0]      session_r, start_r, end_r, present_r;
  logic             ovf_r;
  logic [7:0]       filter_r;
  logic [CNT_W-1:0] used_r;

  kcst_pkg::acc_t   acc_r;
  logic [IDX_W-1:0] scan_r;
  logic [IDX_W-1:0] pos_r;
  logic             create_r;
  logic [3:0]       word_r;

  logic         out_valid_r;
  logic [343:0] out_data_r;
  logic [4:0]   out_user_r;
  logic         out_last_r;

  // ram ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_raddr;
  kcst_pkg::rec_t   ram_rdata, new_row;

  kcst_pkg::mode_t  in_mode;
  kcst_pkg::acc_t   in_acc;
  logic             in_fire, out_free, capturing, emit;
  logic             key_hit, more_to_scan, table_full, rd_ok;
  logic [63:0]      rd_word;

  assign in_mode    = kcst_pkg::mode_t'(in_tuser);
  assign in_acc.key   = in_tdata[191:128];
  assign in_acc.frame = in_tdata[127:64];
  assign in_acc.tag   = in_tdata[223:192];
  assign in_acc.cmd   = in_tdata[255:224];
  assign in_acc.seen  = in_tdata[266:264];
  assign in_acc.fp[0] = in_tdata[330:267];
  assign in_acc.fp[1] = in_tdata[394:331];
  assign in_acc.fp[2] = in_tdata[458:395];

  assign in_tready = (state_r == ST_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign capturing = (phase_r == kcst_pkg::PH_CAPTURING);
  assign emit      = out_free && (state_r == ST_RESP || state_r == ST_RD);

  assign key_hit      = (ram_rdata.key == acc_r.key);
  assign more_to_scan = (CNT_W'(scan_r) + CNT_W'(1)) < used_r;
  assign table_full   = (used_r == CNT_W'(kcst_pkg::MAX_RECORDS));
  assign rd_ok        = CMP_W'(in_tdata[464:459]) < CMP_W'(used_r);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_r == ST_IN && in_fire) begin
      if (in_mode == kcst_pkg::MODE_ACCUM && capturing && used_r != '0) begin
        ram_re = 1'b1;
      end else if (in_mode == kcst_pkg::MODE_READ && rd_ok) begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(in_tdata[464:459]);
      end
    end else if (state_r == ST_SEARCH && !key_hit && more_to_scan) begin
      ram_re    = 1'b1;
      ram_raddr = scan_r + IDX_W'(1);
    end
  end

  assign ram_we = (state_r == ST_UPD);

  kcst_ram #(
    .WIDTH (kcst_pkg::REC_W),
    .DEPTH (kcst_pkg::MAX_RECORDS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (new_row),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kcst_upd u_upd (
    .old_row (ram_rdata),
    .create  (create_r),
    .acc     (acc_r),
    .new_row (new_row)
  );

  always_comb begin
    case (word_r)
      4'd0:    rd_word = ram_rdata.key;
      4'd1:    rd_word = {26'd0, ram_rdata.changed, ram_rdata.seen, ram_rdata.tag};
      4'd2:    rd_word = ram_rdata.first_fr;
      4'd3:    rd_word = ram_rdata.last_fr;
      4'd4:    rd_word = ram_rdata.cmd_total;
      4'd5:    rd_word = ram_rdata.sub_count;
      4'd6:    rd_word = ram_rdata.fp_first[0];
      4'd7:    rd_word = ram_rdata.fp_last[0];
      4'd8:    rd_word = ram_rdata.fp_first[1];
      4'd9:    rd_word = ram_rdata.fp_last[1];
      4'd10:   rd_word = ram_rdata.fp_first[2];
      4'd11:   rd_word = ram_rdata.fp_last[2];
      default: rd_word = '0;
    endcase
  end

  function automatic logic [343:0] pack_out(
    input kcst_pkg::phase_t ph, input logic [63:0] ses, input logic [63:0] st,
    input logic [63:0] en, input logic [63:0] pr, input logic [CNT_W-1:0] cnt,
    input logic ov, input logic [7:0] flt, input logic [63:0] wd);
    logic [343:0] d;
    d          = '0;
    d[1:0]     = ph;
    d[65:2]    = ses;
    d[129:66]  = st;
    d[193:130] = en;
    d[257:194] = pr;
    d[264:258] = 7'(cnt);
    d[265]     = ov;
    d[273:266] = flt;
    d[337:274] = wd;
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      phase_r     <= kcst_pkg::PH_IDLE;
      session_r   <= '0;
      start_r     <= '0;
      end_r       <= '0;
      present_r   <= '0;
      ovf_r       <= 1'b0;
      filter_r    <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IN: begin
          if (in_fire) begin
            acc_r   <= in_acc;
            scan_r  <= '0;
            word_r  <= '0;
            state_r <= ST_RESP;
            case (in_mode)
              kcst_pkg::MODE_START: begin
                session_r <= in_tdata[63:0];
                start_r   <= in_tdata[127:64];
                end_r     <= in_tdata[127:64];
                present_r <= '0;
                ovf_r     <= 1'b0;
                filter_r  <= in_tdata[263:256];
                used_r    <= '0;
                phase_r   <= kcst_pkg::PH_CAPTURING;
              end
              kcst_pkg::MODE_ACCUM: begin
                if (capturing) begin
                  if (used_r == '0) begin
                    create_r <= 1'b1;
                    pos_r    <= '0;
                    state_r  <= ST_UPD;
                  end else begin
                    state_r <= ST_SEARCH;
                  end
                end
              end
              kcst_pkg::MODE_PRESENT: begin
                if (capturing) begin
                  end_r     <= in_tdata[127:64];
                  present_r <= present_r + 64'd1;
                end
              end
              kcst_pkg::MODE_OVERFLOW: begin
                if (capturing) begin
                  ovf_r <= 1'b1;
                end
              end
              kcst_pkg::MODE_STOP: begin
                if (capturing) begin
                  end_r   <= in_tdata[127:64];
                  phase_r <= kcst_pkg::PH_CAPTURED;
                end
              end
              kcst_pkg::MODE_CLEAR: begin
                if (!capturing) begin
                  session_r <= '0;
                  start_r   <= '0;
                  end_r     <= '0;
                  present_r <= '0;
                  ovf_r     <= 1'b0;
                  filter_r  <= '0;
                  used_r    <= '0;
                  phase_r   <= kcst_pkg::PH_IDLE;
                end
              end
              kcst_pkg::MODE_READ: begin
                if (rd_ok) begin
                  state_r <= ST_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SEARCH: begin
          // ram data belongs to scan_r, read in the previous cycle
          if (key_hit) begin
            create_r <= 1'b0;
            pos_r    <= scan_r;
            state_r  <= ST_UPD;
          end else if (more_to_scan) begin
            scan_r <= scan_r + IDX_W'(1);
          end else if (table_full) begin
            ovf_r   <= 1'b1;
            state_r <= ST_RESP;
          end else begin
            create_r <= 1'b1;
            pos_r    <= IDX_W'(used_r);
            state_r  <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (create_r) begin
            used_r <= used_r + CNT_W'(1);
          end
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_data_r  <= pack_out(phase_r, session_r, start_r, end_r, present_r,
                                    used_r, ovf_r, filter_r, 64'd0);
            out_user_r  <= '0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IN;
          end
        end
        ST_RD: begin
          if (out_free) begin
            out_data_r  <= pack_out(phase_r, session_r, start_r, end_r, present_r,
                                    used_r, ovf_r, filter_r, rd_word);
            out_user_r  <= {1'b1, word_r};
            out_last_r  <= (word_r == 4'(kcst_pkg::N_WORDS - 1));
            if (word_r == 4'(kcst_pkg::N_WORDS - 1)) begin
              state_r <= ST_IN;
            end else begin
              word_r <= word_r + 4'd1;
            end
          end
        end
        default: begin
          state_r <= ST_IN;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/kcst_ram.sv]
// ----------------------------------------------------------------------------
// kcst_ram
// simple dual port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module kcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/kcst_upd.sv]
// ----------------------------------------------------------------------------
// kcst_upd
// builds the written-back row of an accumulate request
// ----------------------------------------------------------------------------
module kcst_upd (
  input  kcst_pkg::rec_t old_row,
  input  logic           create,
  input  kcst_pkg::acc_t acc,
  output kcst_pkg::rec_t new_row
);

  kcst_pkg::rec_t base;

  always_comb begin
    if (create) begin
      base          = '0;
      base.key      = acc.key;
      base.tag      = acc.tag;
      base.first_fr = acc.frame;
    end else begin
      base = old_row;
    end
  end

  always_comb begin
    new_row           = base;
    new_row.cmd_total = base.cmd_total + {32'd0, acc.cmd};
    new_row.sub_count = base.sub_count + 64'd1;
    new_row.last_fr   = acc.frame;
    for (int k = 0; k < kcst_pkg::N_KINDS; k++) begin
      if (acc.seen[k]) begin
        if (!base.seen[k]) begin
          new_row.fp_first[k] = acc.fp[k];
          new_row.changed[k]  = 1'b0;
        end else if (base.fp_last[k] != acc.fp[k]) begin
          new_row.changed[k] = 1'b1;
        end
        new_row.fp_last[k] = acc.fp[k];
      end
    end
    new_row.seen = base.seen | acc.seen;
  end

endmodule

[hw/rtl/kcst_checker.sv]
// ----------------------------------------------------------------------------
// kcst_checker
// port level checks of the keyed capture statistics table
// ----------------------------------------------------------------------------
module kcst_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [343:0] out_tdata,
  input logic [4:0]   out_tuser,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[4] |-> out_tuser[3:0] == 4'd0 && out_tlast)
    else $error("summary result with word number or open run");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[264:258] <= 7'(kcst_pkg::MAX_RECORDS))
    else $error("record count beyond capacity");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] && !out_tlast |-> !in_tready)
    else $error("request taken during a record run");

endmodule

bind keyed_capture_stats_table_top kcst_checker u_kcst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the capture stats table against a behavioral table kept in a class,
// with directed sessions, random sessions, random idling and a long out stall
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [2:0]  mode;
    logic [63:0] sess;
    logic [63:0] frame;
    logic [63:0] key;
    logic [31:0] tag;
    logic [31:0] cmd;
    logic [7:0]  filter;
    logic [2:0]  seen;
    logic [63:0] fp [3];
    logic [5:0]  idx;
  } req_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [63:0] session;
    logic [63:0] begin_fr;
    logic [63:0] stop_fr;
    logic [63:0] presents;
    logic [6:0]  records;
    logic        overflow;
    logic [7:0]  filter;
    logic [63:0] word;
    logic [3:0]  word_num;
    logic        valid;
    logic        last;
  } summary_t;

  class stats_scoreboard;
    kcst_pkg::phase_t ph;
    logic [63:0] session, start_fr, end_fr, presents;
    logic        ovf;
    logic [7:0]  filt;
    int          used;
    logic [63:0] keys [kcst_pkg::MAX_RECORDS];
    logic [31:0] tags [kcst_pkg::MAX_RECORDS];
    logic [63:0] first_fr [kcst_pkg::MAX_RECORDS], last_fr [kcst_pkg::MAX_RECORDS];
    logic [63:0] cmds [kcst_pkg::MAX_RECORDS], subs [kcst_pkg::MAX_RECORDS];
    logic [2:0]  seen_b [kcst_pkg::MAX_RECORDS], chg_b [kcst_pkg::MAX_RECORDS];
    logic [63:0] fpf [kcst_pkg::MAX_RECORDS][3], fpl [kcst_pkg::MAX_RECORDS][3];
    summary_t    pending [$];
    int          errors;

    function new();
      ph = kcst_pkg::PH_IDLE;
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      session = 0; start_fr = 0; end_fr = 0; presents = 0;
      ovf = 0; filt = 0; used = 0;
    endfunction

    function summary_t summary(logic [63:0] w, logic [3:0] n, logic v, logic l);
      summary_t s;
      s.state = ph; s.session = session; s.begin_fr = start_fr;
      s.stop_fr = end_fr; s.presents = presents; s.records = used[6:0];
      s.overflow = ovf; s.filter = filt; s.word = w; s.word_num = n;
      s.valid = v; s.last = l;
      return s;
    endfunction

    function void accumulate(req_t r);
      int pos;
      logic [2:0] bit_k;
      pos = used;
      for (int i = 0; i < used; i++)
        if (keys[i] == r.key) begin
          pos = i;
          break;
        end
      if (pos == used) begin
        if (used >= kcst_pkg::MAX_RECORDS) begin
          ovf = 1;
          return;
        end
        used++;
        keys[pos] = r.key; tags[pos] = r.tag; first_fr[pos] = r.frame;
        cmds[pos] = 0; subs[pos] = 0; seen_b[pos] = 0; chg_b[pos] = 0;
        for (int k = 0; k < 3; k++) begin
          fpf[pos][k] = 0;
          fpl[pos][k] = 0;
        end
      end
      cmds[pos] += {32'b0, r.cmd};
      subs[pos] += 1;
      last_fr[pos] = r.frame;
      for (int k = 0; k < 3; k++) begin
        bit_k = 3'b1 << k;
        if (r.seen & bit_k) begin
          if ((seen_b[pos] & bit_k) == 0) begin
            fpf[pos][k] = r.fp[k];
            fpl[pos][k] = r.fp[k];
            chg_b[pos] &= ~bit_k;
          end else begin
            if (fpl[pos][k] != r.fp[k]) chg_b[pos] |= bit_k;
            fpl[pos][k] = r.fp[k];
          end
        end
      end
      seen_b[pos] |= r.seen;
    endfunction

    function void note_request(req_t r);
      logic cap;
      logic [63:0] w;
      int i;
      cap = (ph == kcst_pkg::PH_CAPTURING);
      case (r.mode)
        kcst_pkg::MODE_START: begin
          wipe();
          session = r.sess; start_fr = r.frame; end_fr = r.frame;
          filt = r.filter; ph = kcst_pkg::PH_CAPTURING;
        end
        kcst_pkg::MODE_ACCUM: if (cap) accumulate(r);
        kcst_pkg::MODE_PRESENT: if (cap) begin
          end_fr = r.frame;
          presents += 1;
        end
        kcst_pkg::MODE_OVERFLOW: if (cap) ovf = 1;
        kcst_pkg::MODE_STOP: if (cap) begin
          end_fr = r.frame;
          ph = kcst_pkg::PH_CAPTURED;
        end
        kcst_pkg::MODE_CLEAR: if (!cap) begin
          wipe();
          ph = kcst_pkg::PH_IDLE;
        end
        kcst_pkg::MODE_READ: begin
          i = r.idx;
          if (i < used) begin
            for (int n = 0; n < kcst_pkg::N_WORDS; n++) begin
              case (n)
                0: w = keys[i];
                1: w = {26'b0, chg_b[i], seen_b[i], tags[i]};
                2: w = first_fr[i];
                3: w = last_fr[i];
                4: w = cmds[i];
                5: w = subs[i];
                default: w = ((n - 6) & 1) ? fpl[i][(n - 6) >> 1] : fpf[i][(n - 6) >> 1];
              endcase
              pending.insert(pending.size(),
                             summary(w, 4'(n), 1'b1, n == kcst_pkg::N_WORDS - 1));
            end
            return;
          end
        end
        default: ;
      endcase
      pending.insert(pending.size(), summary(64'd0, 4'd0, 1'b0, 1'b1));
    endfunction

    function void check_result(summary_t got);
      summary_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [471:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [343:0] out_tdata;
  logic [4:0]   out_tuser;
  logic         out_tlast;

  keyed_capture_stats_table_top u_top (.*);

  stats_scoreboard sb;
  int  idle_pct;
  bit  stall_hold;
  bit  sent_done;
  int  quiet_cycles;

  function automatic summary_t take_result();
    summary_t s;
    s.state    = out_tdata[1:0];
    s.session  = out_tdata[65:2];
    s.begin_fr = out_tdata[129:66];
    s.stop_fr  = out_tdata[193:130];
    s.presents = out_tdata[257:194];
    s.records  = out_tdata[264:258];
    s.overflow = out_tdata[265];
    s.filter   = out_tdata[273:266];
    s.word     = out_tdata[337:274];
    s.word_num = out_tuser[3:0];
    s.valid    = out_tuser[4];
    s.last     = out_tlast;
    return s;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(take_result());
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int hold;
    bit held;
    held = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_hold && !held) begin
        held = 1;
        out_tready <= 0;
        for (hold = 0; hold < 400; hold++) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic req_t rand_req(logic [2:0] mode, int key_span);
    req_t r;
    r.mode = mode;
    r.sess = {$urandom, $urandom};
    r.frame = {$urandom, $urandom};
    r.key = (key_span > 0) ? 64'($urandom_range(key_span - 1)) : {$urandom, $urandom};
    r.tag = $urandom; r.cmd = $urandom; r.filter = 8'($urandom);
    r.seen = 3'($urandom);
    for (int k = 0; k < 3; k++)
      r.fp[k] = ($urandom_range(1)) ? 64'($urandom_range(3)) : {$urandom, $urandom};
    r.idx = 6'($urandom);
    return r;
  endfunction

  task automatic send(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= r.mode;
    in_tdata  <= {7'd0, r.idx, r.fp[2], r.fp[1], r.fp[0], r.seen, r.filter, r.cmd,
                  r.tag, r.key, r.frame, r.sess};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_mode(logic [2:0] mode);
    send(rand_req(mode, 0));
  endtask

  initial begin
    req_t r;
    int m;
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    idle_pct = 28; stall_hold = 0; sent_done = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: modes outside a capture, extremes, full table, reads
    send_mode(kcst_pkg::MODE_ACCUM); send_mode(kcst_pkg::MODE_STOP);
    send_mode(kcst_pkg::MODE_READ);
    send_mode(kcst_pkg::MODE_UNUSED); send_mode(kcst_pkg::MODE_CLEAR);
    r = rand_req(kcst_pkg::MODE_START, 0);
    r.sess = '1; r.frame = '1; r.filter = '1;
    send(r);
    send_mode(kcst_pkg::MODE_CLEAR);
    r = rand_req(kcst_pkg::MODE_ACCUM, 0);
    r.key = '1; r.cmd = '1; r.tag = '1; r.seen = 3'b111; r.frame = '1;
    r.fp[0] = '1; r.fp[1] = '1; r.fp[2] = '1;
    send(r); send(r);
    r.key = 0; r.cmd = 0; r.tag = 0; r.seen = 0; r.frame = 0;
    send(r);
    r.idx = 0; r.mode = kcst_pkg::MODE_READ; send(r);
    r.idx = 1; send(r);
    r.idx = '1; send(r);
    send_mode(kcst_pkg::MODE_PRESENT); send_mode(kcst_pkg::MODE_OVERFLOW);
    send_mode(kcst_pkg::MODE_UNUSED);
    send_mode(kcst_pkg::MODE_STOP); send_mode(kcst_pkg::MODE_READ);
    send_mode(kcst_pkg::MODE_START);
    // fill the table past capacity with distinct keys
    for (int i = 0; i < kcst_pkg::MAX_RECORDS + 2; i++) begin
      r = rand_req(kcst_pkg::MODE_ACCUM, 0);
      r.key = 64'(i);
      send(r);
    end
    r.mode = kcst_pkg::MODE_READ; r.idx = 6'(kcst_pkg::MAX_RECORDS - 1); send(r);
    send_mode(kcst_pkg::MODE_STOP); send_mode(kcst_pkg::MODE_CLEAR);

    // random sessions
    for (int s = 0; s < 12; s++) begin
      if (s == 3) idle_pct = 0;
      if (s == 6) idle_pct = 28;
      if (s == 8) stall_hold = 1;
      send_mode(kcst_pkg::MODE_START);
      for (int i = 0; i < 10; i++) begin
        m = $urandom_range(99);
        if (m < 55) send(rand_req(kcst_pkg::MODE_ACCUM, 8));
        else if (m < 70) send_mode(kcst_pkg::MODE_PRESENT);
        else if (m < 85) begin
          r = rand_req(kcst_pkg::MODE_READ, 0);
          r.idx = 6'($urandom_range(9));
          send(r);
        end
        else send_mode(3'($urandom_range(7)));
      end
      send_mode(kcst_pkg::MODE_STOP);
      r = rand_req(kcst_pkg::MODE_READ, 0);
      r.idx = 6'($urandom_range(3));
      send(r);
      if ($urandom_range(1)) send_mode(kcst_pkg::MODE_CLEAR);
    end
    in_tvalid <= 0;
    sent_done = 1;
  end

  // end of run and watchdog
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (quiet_cycles > 5000) begin
        $display("Some tests failed");
        $finish;
      end
      if (sent_done && sb.pending.size() == 0) begin
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
          $display("All tests passed");
        else
          $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
